>>> rtl/msam_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multi-stream audio mixer.
// No dependencies; used by every module of the mixer but msam_ram.
package msam_pkg;

  localparam int N_STREAMS_DEF  = 4;
  localparam int FIFO_DEPTH_DEF = 1024;

  localparam int CMD_W    = 3;
  localparam int SEL_IN_W = 2;
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 8;
  localparam int LEVEL_W  = 10;

  localparam int VOL_MAX = 128;
  localparam int PCM_MAX = 32767;
  localparam int PCM_MIN = -32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_PULL  = 3'd1,
    CMD_PLAY  = 3'd2,
    CMD_PAUSE = 3'd3,
    CMD_STOP  = 3'd4,
    CMD_VOL   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PLAYING = 2'd1,
    ST_PAUSED  = 2'd2
  } play_t;

  typedef struct packed {
    logic [VOL_W-1:0]    volume_value;
    logic [SAMPLE_W-1:0] sample_in;
    logic [SEL_IN_W-1:0] stream_sel;
    logic [CMD_W-1:0]    cmd;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  queued_level;
    logic                accepted;
    logic [SAMPLE_W-1:0] mixed_sample;
  } res_t;

endpackage

>>> rtl/msam_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module msam_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/msam_core.sv
`timescale 1ns / 1ps
// Command sequencer and mix datapath of the audio mixer.
// Depends on msam_pkg and msam_ram (stream context and sample memories).
module msam_core #(
  parameter int N_STREAMS  = msam_pkg::N_STREAMS_DEF,
  parameter int FIFO_DEPTH = msam_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  msam_pkg::req_t req,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output msam_pkg::res_t res
);
  import msam_pkg::*;

  localparam int SEL_W     = (N_STREAMS > 1) ? $clog2(N_STREAMS) : 1;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CTX_DEPTH = 1 << SEL_W;
  localparam int CTX_W     = 2 * PTR_W + 2 + VOL_W;
  localparam int WR_LO     = PTR_W;
  localparam int ST_LO     = 2 * PTR_W;
  localparam int VOL_LO    = 2 * PTR_W + 2;
  localparam int SADDR_W   = SEL_W + PTR_W;
  localparam int PROD_W    = SAMPLE_W + VOL_W + 1;
  localparam int SCL_W     = PROD_W - 7;
  localparam int ACC_W     = SEL_W + 18;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(PCM_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(PCM_MIN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RDSEL,
    S_EXEC
  } state_t;

  function automatic logic [PTR_W-1:0] fifo_level(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, r};
    end
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t state;
  cmd_t cur_cmd;
  logic [SEL_W-1:0] cur_sel;
  logic cur_ok;
  logic [SAMPLE_W-1:0] cur_sample;
  logic [VOL_W-1:0] cur_vol;

  logic [SEL_W-1:0] scan_idx;
  logic p1_v, p2_v, p3_v;
  logic [SEL_W-1:0] p1_idx;
  logic [VOL_W-1:0] p2_vol;
  logic signed [PROD_W-1:0] p3_prod;
  logic signed [ACC_W-1:0] acc;

  logic [CTX_DEPTH-1:0] ctx_vld;
  logic rd_vld;

  logic ctx_wr_en, ctx_rd_en;
  logic [SEL_W-1:0] ctx_wr_addr, ctx_rd_addr;
  logic [CTX_W-1:0] ctx_wr_data, ctx_q, ctx;
  logic smp_wr_en, smp_rd_en;
  logic [SADDR_W-1:0] smp_wr_addr, smp_rd_addr;
  logic [SAMPLE_W-1:0] smp_q;

  logic [PTR_W-1:0] c_rd, c_wr, c_lvl, n_rd, n_wr;
  play_t c_st, n_st;
  logic [VOL_W-1:0] c_vol, n_vol;
  logic hit, push_ok, fire;
  logic signed [SCL_W-1:0] scaled;
  logic [SAMPLE_W-1:0] sat;

  msam_ram #(.DATA_W(CTX_W), .ADDR_W(SEL_W)) u_ctx_ram (
    .clk     (clk),
    .wr_en   (ctx_wr_en),
    .wr_addr (ctx_wr_addr),
    .wr_data (ctx_wr_data),
    .rd_en   (ctx_rd_en),
    .rd_addr (ctx_rd_addr),
    .rd_data (ctx_q)
  );

  msam_ram #(.DATA_W(SAMPLE_W), .ADDR_W(SADDR_W)) u_smp_ram (
    .clk     (clk),
    .wr_en   (smp_wr_en),
    .wr_addr (smp_wr_addr),
    .wr_data (cur_sample),
    .rd_en   (smp_rd_en),
    .rd_addr (smp_rd_addr),
    .rd_data (smp_q)
  );

  always_comb begin
    ctx = rd_vld ? ctx_q : {VOL_W'(VOL_MAX), ST_IDLE, {PTR_W{1'b0}}, {PTR_W{1'b0}}};
    c_rd  = ctx[PTR_W-1:0];
    c_wr  = ctx[WR_LO +: PTR_W];
    c_st  = play_t'(ctx[ST_LO +: 2]);
    c_vol = ctx[VOL_LO +: VOL_W];
    c_lvl = fifo_level(c_wr, c_rd);
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_EXEC);
  assign fire      = res_valid && res_ready;
  assign hit       = p1_v && (c_st == ST_PLAYING) && (c_rd != c_wr);
  assign scaled    = p3_prod[PROD_W-1:7];
  assign push_ok   = cur_ok && (c_st != ST_IDLE) &&
                     ({1'b0, c_lvl} < (PTR_W+1)'(FIFO_DEPTH - 1));

  always_comb begin
    if (acc > ACC_MAX) begin
      sat = SAMPLE_W'(PCM_MAX);
    end else if (acc < ACC_MIN) begin
      sat = SAMPLE_W'(PCM_MIN);
    end else begin
      sat = acc[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    n_rd  = c_rd;
    n_wr  = c_wr;
    n_st  = c_st;
    n_vol = c_vol;
    case (cur_cmd)
      CMD_PUSH: begin
        if (push_ok) begin
          n_wr = ptr_inc(c_wr);
        end
      end
      CMD_PLAY:  n_st = ST_PLAYING;
      CMD_PAUSE: n_st = ST_PAUSED;
      CMD_STOP: begin
        n_st = ST_IDLE;
        n_rd = '0;
        n_wr = '0;
      end
      CMD_VOL: n_vol = (cur_vol > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : cur_vol;
      default: ;
    endcase
  end

  always_comb begin
    res.mixed_sample = (cur_cmd == CMD_PULL) ? sat : '0;
    res.accepted     = (cur_cmd == CMD_PUSH) && push_ok;
    res.queued_level = cur_ok ? LEVEL_W'(fifo_level(n_wr, n_rd)) : '0;
  end

  always_comb begin
    ctx_rd_en   = (state == S_SCAN) || (state == S_RDSEL);
    ctx_rd_addr = (state == S_SCAN) ? scan_idx : cur_sel;
    if (state == S_EXEC) begin
      ctx_wr_en   = fire && cur_ok && (cur_cmd != CMD_PULL);
      ctx_wr_addr = cur_sel;
      ctx_wr_data = {n_vol, n_st, n_wr, n_rd};
    end else begin
      ctx_wr_en   = hit;
      ctx_wr_addr = p1_idx;
      ctx_wr_data = {c_vol, c_st, c_wr, ptr_inc(c_rd)};
    end
    smp_wr_en   = fire && (cur_cmd == CMD_PUSH) && push_ok;
    smp_wr_addr = {cur_sel, c_wr};
    smp_rd_en   = hit;
    smp_rd_addr = {p1_idx, c_rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
      p3_v    <= 1'b0;
      ctx_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      p1_v <= (state == S_SCAN);
      p2_v <= hit;
      p3_v <= p2_v;
      if (ctx_wr_en) begin
        ctx_vld[ctx_wr_addr] <= 1'b1;
      end
      if (ctx_rd_en) begin
        rd_vld <= ctx_vld[ctx_rd_addr];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= (cmd_t'(req.cmd) == CMD_PULL) ? S_SCAN : S_RDSEL;
          end
        end
        S_SCAN: begin
          if (scan_idx == SEL_W'(N_STREAMS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v) begin
            state <= S_RDSEL;
          end
        end
        S_RDSEL: state <= S_EXEC;
        S_EXEC: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur_cmd    <= cmd_t'(req.cmd);
      cur_sel    <= SEL_W'(req.stream_sel);
      cur_ok     <= (32'(req.stream_sel) < 32'(N_STREAMS));
      cur_sample <= req.sample_in;
      cur_vol    <= req.volume_value;
      scan_idx   <= '0;
      acc        <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (p3_v) begin
        acc <= acc + {{(ACC_W-SCL_W){scaled[SCL_W-1]}}, scaled};
      end
    end
    p1_idx  <= scan_idx;
    p2_vol  <= c_vol;
    p3_prod <= $signed(smp_q) * $signed({1'b0, p2_vol});
  end

  a_exec_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !p1_v && !p2_v && !p3_v)
    else $error("result formed with pull pipeline busy");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ctx_wr_en && ctx_rd_en |-> ctx_wr_addr != ctx_rd_addr)
    else $error("context read and write hit the same stream");

  a_mul_follows_read: assert property (@(posedge clk) disable iff (rst)
    p2_v |-> $past(smp_rd_en))
    else $error("product stage without a sample read");

  a_accept_push: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.accepted |-> cur_cmd == CMD_PUSH && cur_ok)
    else $error("accept flag on a non-push word");

endmodule

>>> rtl/multi_stream_audio_mixer_top.sv
`timescale 1ns / 1ps
// Top level of the multi-stream audio mixer: stream ports and result register.
// Depends on msam_pkg and msam_core.
//
// Usage: each word on s_axis is one command (push, pull, play, pause, stop,
// set volume) for a stream; each command returns exactly one word on m_axis
// with the mixed sample, the push-accepted flag and the addressed stream's
// queue level. Streams hold their samples in one shared sample memory and
// their indices, play state and volume in a small context memory.
// Sequence: a non-pull word reads its stream's context, forms its result and
// passes it to the output register; the next word is taken once the core is
// idle again. A pull walks every stream through the context memory, one per
// cycle, then drains a three-stage read, scale and add pipeline and reads the
// addressed stream's context before its result is formed.
// Reset: synchronous, clears all streams to idle, empty, volume 128; the
// sample memory is not cleared and no clearing pass is needed.
// Stall: the result waits in the output register while m_axis_tready is low;
// the next command is still accepted and runs until its own result is ready,
// then holds until the register frees.
module multi_stream_audio_mixer_top #(
  parameter int N_STREAMS  = msam_pkg::N_STREAMS_DEF,
  parameter int FIFO_DEPTH = msam_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], stream_sel[4:3], sample_in[20:5], volume_value[28:21], zero fill
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mixed_sample[15:0], accepted[16], queued_level[26:17], zero fill
  output logic [31:0] m_axis_tdata
);
  import msam_pkg::*;

  localparam int REQ_W = $bits(req_t);
  localparam int RES_W = $bits(res_t);

  req_t req;
  res_t core_res, out_res;
  logic core_idle, core_valid, core_ready;

  assign req           = req_t'(s_axis_tdata[REQ_W-1:0]);
  assign s_axis_tready = core_idle;
  assign core_ready    = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {{(32-RES_W){1'b0}}, out_res};

  msam_core #(
    .N_STREAMS  (N_STREAMS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid),
    .req       (req),
    .idle      (core_idle),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (core_valid && core_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      out_res <= core_res;
    end
  end

endmodule

>>> dv/msam_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-stream audio mixer: shadows every stream's FIFO, play
// state and volume from the accepted command words and checks each result word.
// Depends on msam_pkg.
module msam_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          replies_owed_n,
  output int          mismatch_n
);
  import msam_pkg::*;

  localparam int NSTREAM = N_STREAMS_DEF;
  localparam int DEPTH   = FIFO_DEPTH_DEF;

  logic signed [SAMPLE_W-1:0] pcm_mem [NSTREAM][DEPTH];
  int                         rd_ptr  [NSTREAM];
  int                         wr_ptr  [NSTREAM];
  play_t                      mode    [NSTREAM];
  logic [VOL_W-1:0]           gain    [NSTREAM];
  res_t                       replies_owed [$];
  int                         mismatches = 0;

  function automatic int fill_of(int s);
    return (wr_ptr[s] + DEPTH - rd_ptr[s]) % DEPTH;
  endfunction

  function automatic res_t mix_command(req_t c);
    res_t r;
    int   sel;
    int   sum;
    logic sel_ok;
    r      = '0;
    sel    = int'(c.stream_sel);
    sel_ok = sel < NSTREAM;
    sum    = 0;
    case (c.cmd)
      CMD_PUSH: begin
        if (sel_ok && mode[sel] != ST_IDLE && fill_of(sel) < DEPTH - 1) begin
          pcm_mem[sel][wr_ptr[sel]] = c.sample_in;
          wr_ptr[sel] = (wr_ptr[sel] + 1) % DEPTH;
          r.accepted = 1'b1;
        end
      end
      CMD_PULL: begin
        for (int s = 0; s < NSTREAM; s++) begin
          if (mode[s] == ST_PLAYING && fill_of(s) > 0) begin
            sum += (int'(pcm_mem[s][rd_ptr[s]]) * int'(gain[s])) >>> 7;
            rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
          end
        end
        if (sum > PCM_MAX) sum = PCM_MAX;
        else if (sum < PCM_MIN) sum = PCM_MIN;
        r.mixed_sample = SAMPLE_W'(sum);
      end
      CMD_PLAY:  if (sel_ok) mode[sel] = ST_PLAYING;
      CMD_PAUSE: if (sel_ok) mode[sel] = ST_PAUSED;
      CMD_STOP: begin
        if (sel_ok) begin
          mode[sel]   = ST_IDLE;
          rd_ptr[sel] = 0;
          wr_ptr[sel] = 0;
        end
      end
      CMD_VOL: begin
        if (sel_ok)
          gain[sel] = (c.volume_value > VOL_MAX) ? VOL_W'(VOL_MAX) : c.volume_value;
      end
      default: ;
    endcase
    r.queued_level = sel_ok ? LEVEL_W'(fill_of(sel)) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      for (int s = 0; s < NSTREAM; s++) begin
        rd_ptr[s] = 0;
        wr_ptr[s] = 0;
        mode[s]   = ST_IDLE;
        gain[s]   = VOL_W'(VOL_MAX);
      end
      replies_owed.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[$bits(res_t)-1:0]);
        if (replies_owed.size() == 0) begin
          $display("%0t: result word %h with none owed", $time, m_tdata);
          mismatches++;
        end else begin
          want = replies_owed.pop_front();
          if (got.mixed_sample !== want.mixed_sample) begin
            $display("%0t: mixed_sample expected %0d actual %0d", $time,
                     $signed(want.mixed_sample), $signed(got.mixed_sample));
            mismatches++;
          end
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0b actual %0b", $time,
                     want.accepted, got.accepted);
            mismatches++;
          end
          if (got.queued_level !== want.queued_level) begin
            $display("%0t: queued_level expected %0d actual %0d", $time,
                     want.queued_level, got.queued_level);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_owed.push_back(mix_command(req_t'(s_tdata[$bits(req_t)-1:0])));
    end
    replies_owed_n <= replies_owed.size();
    mismatch_n     <= mismatches;
  end

endmodule

>>> dv/tb_multi_stream_audio_mixer_top.sv
`timescale 1ns / 1ps
// Testbench top for the multi-stream audio mixer: drives command words with
// random gaps and output stalls, and reports the verdict from msam_checker.
// Depends on msam_pkg, msam_checker and multi_stream_audio_mixer_top.
module tb_multi_stream_audio_mixer_top;
  import msam_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int FILL_PUSHES  = FIFO_DEPTH_DEF + 1;
  localparam int RANDOM_WORDS = 190;
  localparam int CALM_TAIL    = 50;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [31:0] in_data   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_data;
  bit          idle_on   = 1'b1;
  int          owed;
  int          mismatches;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multi_stream_audio_mixer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data)
  );

  msam_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (in_valid),
    .s_tready       (in_ready),
    .s_tdata        (in_data),
    .m_tvalid       (out_valid),
    .m_tready       (out_ready),
    .m_tdata        (out_data),
    .replies_owed_n (owed),
    .mismatch_n     (mismatches)
  );

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [SEL_IN_W-1:0] sel,
                           logic [SAMPLE_W-1:0] smp, logic [VOL_W-1:0] vol);
    req_t w;
    w = '{volume_value: vol, sample_in: smp, stream_sel: sel, cmd: cmd};
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= 32'(w);
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL multi_stream_audio_mixer_top");
    $finish;
  end

  initial begin
    int                  op;
    logic [SEL_IN_W-1:0] sel;
    logic [SAMPLE_W-1:0] smp;
    logic [VOL_W-1:0]    vol;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_PUSH, 2'd0, 16'(PCM_MAX), '0);
    send_word(CMD_PULL, 2'd0, '0, '0);
    send_word(CMD_RSVD6, 2'd1, 16'hffff, 8'hff);
    send_word(CMD_RSVD7, 2'd2, 16'h5a5a, 8'ha5);
    for (int s = 0; s < N_STREAMS_DEF; s++) send_word(CMD_PLAY, SEL_IN_W'(s), '0, '0);
    send_word(CMD_VOL, 2'd0, '0, 8'd255);
    send_word(CMD_VOL, 2'd1, '0, VOL_W'(VOL_MAX));
    send_word(CMD_VOL, 2'd2, '0, 8'd0);
    send_word(CMD_VOL, 2'd3, '0, 8'd1);
    send_word(CMD_PUSH, 2'd0, 16'(PCM_MAX), '0);
    send_word(CMD_PUSH, 2'd1, 16'(PCM_MAX), '0);
    send_word(CMD_PUSH, 2'd2, 16'(PCM_MIN), '0);
    send_word(CMD_PUSH, 2'd3, 16'hffff, '0);
    send_word(CMD_PULL, 2'd0, '0, '0);
    send_word(CMD_PUSH, 2'd0, 16'(PCM_MIN), '0);
    send_word(CMD_PUSH, 2'd1, 16'(PCM_MIN), '0);
    send_word(CMD_PULL, 2'd0, '0, '0);
    send_word(CMD_PUSH, 2'd1, 16'd5, '0);
    send_word(CMD_STOP, 2'd1, '0, '0);
    send_word(CMD_STOP, 2'd2, '0, '0);
    send_word(CMD_PAUSE, 2'd2, '0, '0);
    send_word(CMD_PUSH, 2'd2, 16'd100, '0);
    send_word(CMD_PULL, 2'd0, '0, '0);

    // fill stream 3 past full while paused, then let it play
    send_word(CMD_STOP, 2'd3, '0, '0);
    send_word(CMD_PAUSE, 2'd3, '0, '0);
    repeat (FILL_PUSHES) send_word(CMD_PUSH, 2'd3, 16'($urandom), 8'($urandom));
    send_word(CMD_PLAY, 2'd3, '0, '0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      idle_on = (k < RANDOM_WORDS - CALM_TAIL) && ((k / 40) % 4 != 3);
      op  = $urandom_range(0, 99);
      sel = SEL_IN_W'($urandom);
      smp = 16'($urandom);
      vol = 8'($urandom);
      if (op < 44) begin
        case ($urandom_range(0, 15))
          0: smp = 16'(PCM_MAX);
          1: smp = 16'(PCM_MIN);
          2: smp = 16'hffff;
          3: smp = '0;
          default: ;
        endcase
        send_word(CMD_PUSH, sel, smp, vol);
      end else if (op < 74) begin
        send_word(CMD_PULL, sel, smp, vol);
      end else if (op < 81) begin
        send_word(CMD_PLAY, sel, smp, vol);
      end else if (op < 85) begin
        send_word(CMD_PAUSE, sel, smp, vol);
      end else if (op < 87) begin
        send_word(CMD_STOP, sel, smp, vol);
      end else if (op < 95) begin
        if ($urandom_range(0, 3) == 0) vol = VOL_W'(VOL_MAX);
        send_word(CMD_VOL, sel, smp, vol);
      end else begin
        send_word($urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7, sel, smp, vol);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0 && owed == 0)
      $display("PASS multi_stream_audio_mixer_top");
    else
      $display("FAIL multi_stream_audio_mixer_top");
    $finish;
  end

endmodule
